// ===== src/fcw_pkg.sv =====
// Shared types, codes and constants of the FAT12 cluster chain walker.
package fcw_pkg;

	localparam int FAT_BYTES_DEFAULT = 4608;

	localparam int ADDR_W    = 13;
	localparam int CLUSTER_W = 12;
	localparam int SIZE_W    = 32;
	localparam int SECTOR_W  = 13;
	localparam int COUNT_W   = 10;

	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_START   = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	localparam logic [CLUSTER_W-1:0] END_MARK_LOW = 12'hFF8;
	localparam logic [SECTOR_W-1:0]  DATA_OFFSET  = 13'd31;
	localparam logic [COUNT_W-1:0]   SECTOR_BYTES = 10'd512;

	typedef struct packed {
		logic [1:0]           kind;
		logic [ADDR_W-1:0]    table_address;
		logic [7:0]           table_byte;
		logic [CLUSTER_W-1:0] start_cluster;
		logic [SIZE_W-1:0]    file_length;
	} in_item_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [COUNT_W-1:0]  byte_count;
		logic                last;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic write_en;
		logic load_start;
		logic load_advance;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic chain_active;
	} status_t;

endpackage

// ===== src/fcw_ctrl.sv =====
// Controller state machine of the FAT12 cluster chain walker.
module fcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          kind,
	input  fcw_pkg::status_t    status,
	output logic                busy,
	output logic                result_valid,
	output fcw_pkg::cmd_t       cmd
);

	fcw_pkg::state_t state_q;
	fcw_pkg::state_t state_d;
	logic            accept;
	logic            begins_report;

	assign accept = start && (state_q == fcw_pkg::ST_IDLE);
	assign begins_report = accept && ((kind == fcw_pkg::KIND_START) ||
		((kind == fcw_pkg::KIND_ADVANCE) && status.chain_active));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcw_pkg::ST_IDLE: begin
				if (begins_report) begin
					state_d = fcw_pkg::ST_REPORT;
				end
			end
			fcw_pkg::ST_REPORT: begin
				state_d = fcw_pkg::ST_IDLE;
			end
			default: state_d = fcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b0;
		result_valid = 1'b0;
		unique case (state_q)
			fcw_pkg::ST_IDLE: begin
				cmd.write_en     = accept && (kind == fcw_pkg::KIND_WRITE);
				cmd.load_start   = accept && (kind == fcw_pkg::KIND_START);
				cmd.load_advance = accept && (kind == fcw_pkg::KIND_ADVANCE) &&
					status.chain_active;
			end
			fcw_pkg::ST_REPORT: begin
				busy         = 1'b1;
				result_valid = 1'b1;
				cmd.report   = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

// ===== src/fcw_datapath.sv =====
// Datapath: FAT byte memory, chain registers and entry decode.
module fcw_datapath #(
	parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fcw_pkg::in_item_t   item,
	input  fcw_pkg::cmd_t       cmd,
	output fcw_pkg::status_t    status,
	output fcw_pkg::out_item_t  result
);

	localparam int AW = $clog2(FAT_BYTES);
	localparam logic [fcw_pkg::ADDR_W-1:0] LIMIT = fcw_pkg::ADDR_W'(FAT_BYTES);

	logic [7:0] mem [FAT_BYTES];

	logic [fcw_pkg::CLUSTER_W-1:0] current_q;
	logic [fcw_pkg::CLUSTER_W-1:0] link_q;
	logic [fcw_pkg::COUNT_W-1:0]   tail_q;
	logic                          chain_q;
	logic                          parity_q;
	logic                          ok0_q;
	logic                          ok1_q;
	logic [7:0]                    rd0_q;
	logic [7:0]                    rd1_q;

	logic [fcw_pkg::CLUSTER_W-1:0] cluster_sel;
	logic [fcw_pkg::ADDR_W:0]      triple;
	logic [fcw_pkg::ADDR_W-1:0]    off0;
	logic [fcw_pkg::ADDR_W-1:0]    off1;
	logic                          load;
	logic [fcw_pkg::COUNT_W-1:0]   tail_d;
	logic [7:0]                    b0;
	logic [7:0]                    b1;
	logic [fcw_pkg::CLUSTER_W-1:0] entry;
	logic                          is_last;

	assign load = cmd.load_start || cmd.load_advance;
	assign cluster_sel = cmd.load_start ? item.start_cluster : link_q;

	// Entry offset 3*c/2; its two bytes are read in the accept cycle.
	assign triple = {2'b00, cluster_sel} + {1'b0, cluster_sel, 1'b0};
	assign off0 = triple[fcw_pkg::ADDR_W:1];
	assign off1 = off0 + fcw_pkg::ADDR_W'(1);

	always_comb begin
		tail_d = {1'b0, item.file_length[8:0]};
		if ((item.file_length[8:0] == '0) && (item.file_length != '0)) begin
			tail_d = fcw_pkg::SECTOR_BYTES;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && (item.table_address < LIMIT)) begin
			mem[item.table_address[AW-1:0]] <= item.table_byte;
		end
		if (load) begin
			rd0_q <= mem[off0[AW-1:0]];
			rd1_q <= mem[off1[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
			link_q    <= '0;
			tail_q    <= '0;
			chain_q   <= 1'b0;
			parity_q  <= 1'b0;
			ok0_q     <= 1'b0;
			ok1_q     <= 1'b0;
		end else begin
			if (load) begin
				current_q <= cluster_sel;
				parity_q  <= cluster_sel[0];
				ok0_q     <= off0 < LIMIT;
				ok1_q     <= off1 < LIMIT;
			end
			if (cmd.load_start) begin
				tail_q <= tail_d;
			end
			if (cmd.report) begin
				link_q  <= entry;
				chain_q <= !is_last;
			end
		end
	end

	// Bytes past the table end read as zero.
	assign b0 = ok0_q ? rd0_q : 8'h00;
	assign b1 = ok1_q ? rd1_q : 8'h00;
	assign entry = parity_q ? {b1, b0[7:4]} : {b1[3:0], b0};
	assign is_last = entry >= fcw_pkg::END_MARK_LOW;

	assign result.sector     = {1'b0, current_q} + fcw_pkg::DATA_OFFSET;
	assign result.byte_count = is_last ? tail_q : fcw_pkg::SECTOR_BYTES;
	assign result.last       = is_last;
	assign status.chain_active = chain_q;

endmodule

// ===== src/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker.
// A write transaction (kind 0) stores one FAT byte and gives no result;
// addresses at or past FAT_BYTES are dropped. For a start transaction
// (kind 1) or an advance transaction (kind 2, only while a chain is
// active), the accept cycle reads both bytes of the cluster's 12-bit
// entry from the two read ports of the FAT memory, and the next cycle
// raises result_valid for exactly one cycle with the data sector
// (cluster + 31), the byte count and the last flag. busy is high in that
// result cycle, so a chain step holds off the next transaction, while
// writes are taken at one per cycle. The receiver cannot stall:
// result must be captured in the cycle result_valid is high. An advance
// with no active chain and kind 3 are accepted and dropped. The FAT memory
// has no reset; entries must be written before the chain reads them.
module fat12_cluster_chain_walker #(
	parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fcw_pkg::in_item_t   item,
	output logic                result_valid,
	output fcw_pkg::out_item_t  result
);

	fcw_pkg::cmd_t    cmd;
	fcw_pkg::status_t status;

	// Sequencer: decodes the transaction kind and paces the result cycle.
	fcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (item.kind),
		.status       (status),
		.busy         (busy),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	// Memory, cluster/link/tail registers and entry decode.
	fcw_datapath #(
		.FAT_BYTES (FAT_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// ===== src/fcw_checker.sv =====
// Port-level checker of the FAT12 cluster chain walker, with its bind.
module fcw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input fcw_pkg::in_item_t  item,
	input logic               result_valid,
	input fcw_pkg::out_item_t result
);

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while not busy");

	a_single_cycle_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result held longer than one cycle");

	a_start_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.kind == fcw_pkg::KIND_START)) |=> result_valid)
		else $error("start transaction gave no result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.kind == fcw_pkg::KIND_WRITE)) |=> !result_valid)
		else $error("write transaction gave a result");

	a_full_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> (result.byte_count == fcw_pkg::SECTOR_BYTES))
		else $error("non-last sector without full byte count");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (.*);

// ===== tb/fat12_cluster_chain_walker_checker.sv =====
// Checker for the FAT12 cluster chain walker: predicts each report and compares.
module fat12_cluster_chain_walker_checker #(
	parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  fcw_pkg::in_item_t  item,
	input  logic               result_valid,
	input  fcw_pkg::out_item_t result,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import fcw_pkg::*;

	logic [7:0]           fat_copy [FAT_BYTES];
	logic [CLUSTER_W-1:0] cluster_now;
	logic [COUNT_W-1:0]   tail_count;
	logic                 walking;
	out_item_t            expected_reports [$];

	// 12-bit FAT entry of a cluster; bytes past the table read as zero
	function automatic logic [CLUSTER_W-1:0] fat_link(input logic [CLUSTER_W-1:0] c);
		int unsigned off;
		logic [7:0]  lo;
		logic [7:0]  hi;
		off = (3 * int'(c)) >> 1;
		lo  = (off < FAT_BYTES) ? fat_copy[off] : 8'h00;
		hi  = (off + 1 < FAT_BYTES) ? fat_copy[off + 1] : 8'h00;
		return c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
	endfunction

	// queue the report for cluster_now and update the walking flag
	task automatic queue_report();
		out_item_t exp;
		logic      ends;
		ends           = fat_link(cluster_now) >= END_MARK_LOW;
		exp.sector     = SECTOR_W'(cluster_now) + DATA_OFFSET;
		exp.byte_count = ends ? tail_count : SECTOR_BYTES;
		exp.last       = ends;
		walking        = !ends;
		expected_reports.push_back(exp);
	endtask

	always @(posedge clk) begin
		out_item_t exp;
		logic [8:0] rem;
		if (!arst_n) begin
			cluster_now = '0;
			tail_count  = '0;
			walking     = 1'b0;
			mismatches  = 0;
			expected_reports.delete();
		end else begin
			if (result_valid) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: sector %0d count %0d last %0b",
							result.sector, result.byte_count, result.last);
				end else begin
					exp = expected_reports.pop_front();
					if (result.sector !== exp.sector || result.byte_count !== exp.byte_count ||
							result.last !== exp.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected sector %0d count %0d last %0b, got sector %0d count %0d last %0b",
								exp.sector, exp.byte_count, exp.last,
								result.sector, result.byte_count, result.last);
					end
				end
			end
			if (start && !busy) begin
				case (item.kind)
					KIND_WRITE: begin
						if (item.table_address < FAT_BYTES)
							fat_copy[item.table_address] = item.table_byte;
					end
					KIND_START: begin
						rem         = item.file_length[8:0];
						tail_count  = (rem == 0 && item.file_length != 0) ? SECTOR_BYTES
							: COUNT_W'(rem);
						cluster_now = item.start_cluster;
						queue_report();
					end
					KIND_ADVANCE: begin
						if (walking) begin
							cluster_now = fat_link(cluster_now);
							queue_report();
						end
					end
					default: ;
				endcase
			end
		end
		outstanding = expected_reports.size();
	end

endmodule

// ===== tb/fat12_cluster_chain_walker_tb.sv =====
// Testbench top for the FAT12 cluster chain walker: stimulus, timeout and verdict.
module fat12_cluster_chain_walker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcw_pkg::*;

	// small table, so that loading all of it stays short
	localparam int TABLE_BYTES = 768;
	// highest cluster whose two entry bytes both sit inside the table
	localparam int MAX_LINKABLE = (2 * (TABLE_BYTES - 2) + 1) / 3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	logic      result_valid;
	out_item_t result;
	int        mismatches;
	int        outstanding;

	// image of the table as written so far; only used to compose entry writes
	logic [7:0] fat_image [TABLE_BYTES];
	int         sent = 0;
	int         cycle_count = 0;

	always #5 clk = ~clk;

	fat12_cluster_chain_walker #(.FAT_BYTES(TABLE_BYTES)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result)
	);

	fat12_cluster_chain_walker_checker #(.FAT_BYTES(TABLE_BYTES)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// hard stop in case the block hangs or never drops busy
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fat12_cluster_chain_walker_tb failed");
			$finish;
		end
	end

	// every field random; callers override what matters for the kind
	function automatic in_item_t rand_item(input logic [1:0] kind);
		in_item_t it;
		it.kind          = kind;
		it.table_address = ADDR_W'($urandom_range(0, 8191));
		it.table_byte    = 8'($urandom);
		it.start_cluster = CLUSTER_W'($urandom);
		it.file_length   = $urandom;
		return it;
	endfunction

	// Present one transaction and hold it until accepted (start high, busy low
	// at the edge). Afterwards, depending on the idle phase, it may drop start
	// before the next one. start is never lowered when the next transaction follows
	// directly, so it gets one nonblocking update per step at most.
	task automatic issue(input in_item_t it);
		int gap;
		int idle_pct;
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (it.kind == KIND_WRITE && it.table_address < TABLE_BYTES)
			fat_image[it.table_address] = it.table_byte;
		sent++;
		// phases of 200 transactions: none, sender idle 74%, none, sender idle 33%
		case ((sent / 200) % 4)
			1: idle_pct = 74;
			3: idle_pct = 33;
			default: idle_pct = 0;
		endcase
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_byte(input int addr, input logic [7:0] value);
		in_item_t it;
		it = rand_item(KIND_WRITE);
		it.table_address = ADDR_W'(addr);
		it.table_byte    = value;
		issue(it);
	endtask

	task automatic start_chain(input int cluster, input logic [31:0] size);
		in_item_t it;
		it = rand_item(KIND_START);
		it.start_cluster = CLUSTER_W'(cluster);
		it.file_length   = size;
		issue(it);
	endtask

	task automatic advance();
		issue(rand_item(KIND_ADVANCE));
	endtask

	// Set the 12-bit entry of cluster c to v with two byte writes. The shared
	// nibble keeps the neighbor's half from the table image.
	task automatic link_cluster(input int c, input logic [11:0] v);
		int off;
		off = (3 * c) >> 1;
		if (c[0]) begin
			write_byte(off, {v[3:0], fat_image[off][3:0]});
			write_byte(off + 1, v[11:4]);
		end else begin
			write_byte(off, v[7:0]);
			write_byte(off + 1, {fat_image[off + 1][7:4], v[11:8]});
		end
	endtask

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 2048);
			2: return 32'(512 * $urandom_range(0, 8));
			3: return 32'hFFFF_FE00 + $urandom_range(0, 511);
			default: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
		endcase
	endfunction

	initial begin
		int        hops;
		int        links;
		int        chain [8];
		logic [1:0] kind;
		logic [11:0] tail_link;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: things that touch no table byte come first.
		advance();                               // advance with no chain
		issue(rand_item(2'd3));                  // unused kind
		write_byte(TABLE_BYTES, 8'hFF);          // write just past the table
		write_byte(8191, 8'h00);                 // highest address, also dropped

		// Load the whole table so that no walk ever reads an unwritten byte.
		for (int a = 0; a < TABLE_BYTES; a++)
			write_byte(a, (a == 0) ? 8'h00 : (a == TABLE_BYTES - 1) ? 8'hFF : 8'($urandom));

		// Two-link chain ending on 0xFFF, zero file size: tail count is zero.
		link_cluster(2, 12'd5);
		link_cluster(5, 12'hFFF);
		start_chain(2, 32'd0);
		advance();
		advance();                               // chain already ended
		// Lowest end mark, size an exact multiple of a sector: tail is 512.
		link_cluster(7, 12'hFF8);
		start_chain(7, 32'd512);
		// 0xFF7 is no end mark; it leads to a cluster beyond the table.
		link_cluster(8, 12'hFF7);
		start_chain(8, 32'hFFFF_FFFF);
		advance();
		advance();
		// Highest cluster, entry beyond the table reads as zero.
		start_chain(4095, 32'd1);
		// Two-cluster loop, then a start in the middle of the walk.
		link_cluster(10, 12'd11);
		link_cluster(11, 12'd10);
		start_chain(10, 32'd513);
		advance();
		advance();
		advance();
		link_cluster(MAX_LINKABLE, 12'hFFF);
		start_chain(MAX_LINKABLE, 32'd1);

		// Random part: mostly well-formed chains with random content, the rest
		// single random transactions of any kind.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 60) begin
				links = $urandom_range(1, 6);
				for (int i = 0; i < links; i++)
					chain[i] = $urandom_range(0, MAX_LINKABLE);
				for (int i = 0; i + 1 < links; i++)
					link_cluster(chain[i], 12'(chain[i + 1]));
				// usually an end mark; sometimes a link that runs on into the table
				tail_link = ($urandom_range(0, 7) == 0) ? 12'($urandom)
					: 12'($urandom_range(12'hFF8, 12'hFFF));
				link_cluster(chain[links - 1], tail_link);
				start_chain(chain[0], pick_size());
				// short, exact or overlong walks; a cut-short walk is followed
				// by a start while the chain is still active
				hops = $urandom_range(0, links + 1);
				for (int i = 0; i < hops; i++)
					advance();
			end else begin
				kind = 2'($urandom_range(0, 3));
				issue(rand_item(kind));
			end
		end

		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		// a start/advance in flight yields its report in the cycle after accept
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("fat12_cluster_chain_walker_tb passed");
		else
			$display("fat12_cluster_chain_walker_tb failed");
		$finish;
	end

endmodule
